// ===== rtl/clr_pkg.sv =====
// Shared item types, register map and constants of the clipped line run rasterizer.
`default_nettype none
package clr_pkg;

  localparam int DIM_W      = 11;
  localparam int FIELD_W    = 16;
  localparam int COLOR_W    = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd240;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd320;

  // Register indexes (byte address divided by four).
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic signed [FIELD_W-1:0] x_start;
    logic signed [FIELD_W-1:0] y_start;
    logic signed [FIELD_W-1:0] x_end;
    logic signed [FIELD_W-1:0] y_end;
    logic [COLOR_W-1:0]        pen_color;
  } in_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]   run_x;
    logic [DIM_W-1:0]   run_y;
    logic [DIM_W-1:0]   run_length;
    logic               vertical;
    logic [COLOR_W-1:0] run_color;
    logic               last;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/clr_cfg.sv =====
// APB-style register file holding the screen size.
`default_nettype none
module clr_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [clr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [clr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [clr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                  pready,
  output logic      [clr_pkg::DIM_W-1:0]        screen_width,
  output logic      [clr_pkg::DIM_W-1:0]        screen_height
);

  logic [clr_pkg::DIM_W-1:0] width_r;
  logic [clr_pkg::DIM_W-1:0] height_r;
  logic                      reg_index;
  logic                      wr_en;

  assign reg_index = paddr[clr_pkg::CFG_ADDR_W-1];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= clr_pkg::WIDTH_RESET;
      height_r <= clr_pkg::HEIGHT_RESET;
    end else if (wr_en) begin
      case (reg_index)
        clr_pkg::REG_SCREEN_WIDTH:  width_r  <= pwdata[clr_pkg::DIM_W-1:0];
        clr_pkg::REG_SCREEN_HEIGHT: height_r <= pwdata[clr_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      clr_pkg::REG_SCREEN_WIDTH:
        prdata = {{(clr_pkg::CFG_DATA_W-clr_pkg::DIM_W){1'b0}}, width_r};
      clr_pkg::REG_SCREEN_HEIGHT:
        prdata = {{(clr_pkg::CFG_DATA_W-clr_pkg::DIM_W){1'b0}}, height_r};
      default: prdata = '0;
    endcase
  end

  assign screen_width  = width_r;
  assign screen_height = height_r;

endmodule
`default_nettype wire

// ===== rtl/clr_setup.sv =====
// Start-item decode: rejection, clamping, steep swap, ordering and Bresenham setup.
`default_nettype none
module clr_setup #(
  parameter int COORD_BITS = 16
) (
  input  wire clr_pkg::in_item_t              item,
  input  wire logic [clr_pkg::DIM_W-1:0]      screen_width,
  input  wire logic [clr_pkg::DIM_W-1:0]      screen_height,
  output logic                                line_ok,
  output logic                                steep,
  output logic                                minor_dir,
  output logic signed [COORD_BITS:0]          major_pos,
  output logic signed [COORD_BITS:0]          major_end,
  output logic signed [COORD_BITS:0]          minor_pos,
  output logic signed [COORD_BITS:0]          delta_major,
  output logic signed [COORD_BITS:0]          delta_minor,
  output logic signed [COORD_BITS:0]          error_init
);

  localparam int CW = COORD_BITS + 1;

  logic signed [CW-1:0] xa, ya, xb, yb, wd, hd;
  logic signed [CW-1:0] xac, yac, xbc, ybc;
  logic signed [CW-1:0] dx, dy, adx, ady;
  logic signed [CW-1:0] ma, mb, na, nb;
  logic                 swap;

  // Only the low COORD_BITS bits of each coordinate count, as a signed value.
  assign xa = {item.x_start[COORD_BITS-1], item.x_start[COORD_BITS-1:0]};
  assign ya = {item.y_start[COORD_BITS-1], item.y_start[COORD_BITS-1:0]};
  assign xb = {item.x_end[COORD_BITS-1], item.x_end[COORD_BITS-1:0]};
  assign yb = {item.y_end[COORD_BITS-1], item.y_end[COORD_BITS-1:0]};
  assign wd = {{(CW-clr_pkg::DIM_W){1'b0}}, screen_width};
  assign hd = {{(CW-clr_pkg::DIM_W){1'b0}}, screen_height};

  assign line_ok = !((ya < 0 && yb < 0) || (ya > hd && yb > hd) ||
                     (xa < 0 && xb < 0) || (xa > wd && xb > wd));

  assign xac = xa[CW-1] ? '0 : xa;
  assign yac = ya[CW-1] ? '0 : ya;
  assign xbc = xb[CW-1] ? '0 : xb;
  assign ybc = yb[CW-1] ? '0 : yb;

  assign dx  = xac - xbc;
  assign dy  = yac - ybc;
  assign adx = dx[CW-1] ? -dx : dx;
  assign ady = dy[CW-1] ? -dy : dy;

  assign steep = ady > adx;

  always_comb begin
    ma = steep ? yac : xac;
    mb = steep ? ybc : xbc;
    na = steep ? xac : yac;
    nb = steep ? xbc : ybc;
    swap = ma > mb;
    major_pos = swap ? mb : ma;
    major_end = swap ? ma : mb;
    minor_pos = swap ? nb : na;
    minor_dir = swap ? !(nb < na) : !(na < nb);
  end

  assign delta_major = steep ? ady : adx;
  assign delta_minor = steep ? adx : ady;
  assign error_init  = delta_major >>> 1;

endmodule
`default_nettype wire

// ===== rtl/clr_clip.sv =====
// Clips one run against the screen and forms the result item fields.
`default_nettype none
module clr_clip #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                           steep,
  input  wire logic signed [COORD_BITS:0]     major_start,
  input  wire logic signed [COORD_BITS:0]     minor,
  input  wire logic signed [COORD_BITS:0]     len,
  input  wire logic [clr_pkg::DIM_W-1:0]      screen_width,
  input  wire logic [clr_pkg::DIM_W-1:0]      screen_height,
  output logic                                visible,
  output logic [clr_pkg::DIM_W-1:0]           run_x,
  output logic [clr_pkg::DIM_W-1:0]           run_y,
  output logic [clr_pkg::DIM_W-1:0]           run_length
);

  localparam int CW = COORD_BITS + 1;

  logic signed [CW-1:0] x, y, wd, hd, lim, clipped;
  logic signed [CW:0]   far_end;

  assign wd  = {{(CW-clr_pkg::DIM_W){1'b0}}, screen_width};
  assign hd  = {{(CW-clr_pkg::DIM_W){1'b0}}, screen_height};
  assign x   = steep ? minor : major_start;
  assign y   = steep ? major_start : minor;
  assign lim = steep ? hd : wd;

  assign visible = !(x >= wd || y >= hd || len < 1);

  // Last pixel of the run along its own axis; a run crossing the edge stops there.
  assign far_end = {major_start[CW-1], major_start} + {len[CW-1], len} - 1'b1;
  assign clipped = (far_end >= {lim[CW-1], lim}) ? (lim - major_start) : len;

  assign run_x      = x[clr_pkg::DIM_W-1:0];
  assign run_y      = y[clr_pkg::DIM_W-1:0];
  assign run_length = clipped[clr_pkg::DIM_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/clipped_line_run_rasterizer.sv =====
// Top level of the clipped line run rasterizer: input stage, line state, result stage.
`default_nettype none
// A start item (mode 0) loads a line and yields no result; each step item (mode 1)
// advances one pixel along the major axis and may yield one run, clipped to the
// screen size held in the two APB registers. One item is taken per clock unless a
// result waits unread on the output; an accepted item is held in the input register
// while the Bresenham step and the clip are evaluated, and its result, if any, then
// goes to the output register. Every item reads and writes the line state. Write
// the registers only while no line is being drawn.
module clipped_line_run_rasterizer #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire clr_pkg::in_item_t                in_item,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output clr_pkg::out_item_t                    out_item,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [clr_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [clr_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic      [clr_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int CW = COORD_BITS + 1;

  logic [clr_pkg::DIM_W-1:0] screen_width;
  logic [clr_pkg::DIM_W-1:0] screen_height;

  // Input stage.
  logic               s1_valid_r;
  clr_pkg::in_item_t  s1_item_r;
  logic               advance;

  // Line state.
  logic                         active_r, active_nxt;
  logic                         steep_r, steep_nxt;
  logic                         minor_dir_r, minor_dir_nxt;
  logic signed [CW-1:0]         major_pos_r, major_pos_nxt;
  logic signed [CW-1:0]         major_end_r, major_end_nxt;
  logic signed [CW-1:0]         minor_pos_r, minor_pos_nxt;
  logic signed [CW-1:0]         run_begin_r, run_begin_nxt;
  logic signed [CW-1:0]         error_r, error_nxt;
  logic signed [CW-1:0]         delta_major_r, delta_major_nxt;
  logic signed [CW-1:0]         delta_minor_r, delta_minor_nxt;
  logic [clr_pkg::COLOR_W-1:0]  color_r, color_nxt;

  // Result stage.
  logic               out_valid_r, out_valid_nxt;
  clr_pkg::out_item_t out_item_r, out_item_nxt;

  // Setup results.
  logic                 su_ok, su_steep, su_minor_dir;
  logic signed [CW-1:0] su_major_pos, su_major_end, su_minor_pos;
  logic signed [CW-1:0] su_delta_major, su_delta_minor, su_error;

  // Step terms.
  logic signed [CW-1:0] err_sub, major_inc, run_len;
  logic                 minor_move, done, have_run;
  logic                 clip_visible;
  logic [clr_pkg::DIM_W-1:0] clip_x, clip_y, clip_len;

  clr_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (cfg_psel),
    .penable       (cfg_penable),
    .pwrite        (cfg_pwrite),
    .paddr         (cfg_paddr),
    .pwdata        (cfg_pwdata),
    .prdata        (cfg_prdata),
    .pready        (cfg_pready),
    .screen_width  (screen_width),
    .screen_height (screen_height)
  );

  clr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .item          (s1_item_r),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .line_ok       (su_ok),
    .steep         (su_steep),
    .minor_dir     (su_minor_dir),
    .major_pos     (su_major_pos),
    .major_end     (su_major_end),
    .minor_pos     (su_minor_pos),
    .delta_major   (su_delta_major),
    .delta_minor   (su_delta_minor),
    .error_init    (su_error)
  );

  // Bresenham step: the run emitted always spans run_begin up to the current pixel, before clipping.
  assign err_sub    = error_r - delta_minor_r;
  assign minor_move = err_sub[CW-1];
  assign major_inc  = major_pos_r + 1'b1;
  assign done       = major_inc > major_end_r;
  assign have_run   = minor_move || (done && (major_inc > run_begin_r));
  assign run_len    = major_inc - run_begin_r;

  clr_clip #(.COORD_BITS(COORD_BITS)) u_clip (
    .steep         (steep_r),
    .major_start   (run_begin_r),
    .minor         (minor_pos_r),
    .len           (run_len),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .visible       (clip_visible),
    .run_x         (clip_x),
    .run_y         (clip_y),
    .run_length    (clip_len)
  );

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    active_nxt      = active_r;
    steep_nxt       = steep_r;
    minor_dir_nxt   = minor_dir_r;
    major_pos_nxt   = major_pos_r;
    major_end_nxt   = major_end_r;
    minor_pos_nxt   = minor_pos_r;
    run_begin_nxt   = run_begin_r;
    error_nxt       = error_r;
    delta_major_nxt = delta_major_r;
    delta_minor_nxt = delta_minor_r;
    color_nxt       = color_r;
    out_valid_nxt   = 1'b0;
    out_item_nxt.run_x      = clip_x;
    out_item_nxt.run_y      = clip_y;
    out_item_nxt.run_length = clip_len;
    out_item_nxt.vertical   = steep_r;
    out_item_nxt.run_color  = color_r;
    out_item_nxt.last       = done;
    if (s1_valid_r) begin
      if (s1_item_r.mode == clr_pkg::MODE_START) begin
        // A start replaces any line in progress, even when the new one is rejected.
        color_nxt       = s1_item_r.pen_color;
        active_nxt      = su_ok;
        steep_nxt       = su_steep;
        minor_dir_nxt   = su_minor_dir;
        major_pos_nxt   = su_major_pos;
        major_end_nxt   = su_major_end;
        minor_pos_nxt   = su_minor_pos;
        run_begin_nxt   = su_major_pos;
        error_nxt       = su_error;
        delta_major_nxt = su_delta_major;
        delta_minor_nxt = su_delta_minor;
      end else if (active_r) begin
        out_valid_nxt = have_run && clip_visible;
        major_pos_nxt = major_inc;
        active_nxt    = !done;
        if (minor_move) begin
          run_begin_nxt = major_inc;
          minor_pos_nxt = minor_dir_r ? (minor_pos_r - 1'b1) : (minor_pos_r + 1'b1);
          error_nxt     = err_sub + delta_major_r;
        end else begin
          error_nxt = err_sub;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      active_r    <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= out_valid_nxt;
        active_r    <= active_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_item_r    <= out_item_nxt;
      steep_r       <= steep_nxt;
      minor_dir_r   <= minor_dir_nxt;
      major_pos_r   <= major_pos_nxt;
      major_end_r   <= major_end_nxt;
      minor_pos_r   <= minor_pos_nxt;
      run_begin_r   <= run_begin_nxt;
      error_r       <= error_nxt;
      delta_major_r <= delta_major_nxt;
      delta_minor_r <= delta_minor_nxt;
      color_r       <= color_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// ===== tb/clr_run_checker.sv =====
// Checker for the clipped line run rasterizer: predicts each run and compares result items.
module clr_run_checker
  import clr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_item,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [CFG_DATA_W-1:0] cfg_prdata,
  input  logic                  cfg_pready,
  output int                    fail_count,
  output int                    runs_pending,
  output int                    runs_seen,
  output int                    last_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // Screen size and line state as the block should hold them.
  int               scr_w;
  int               scr_h;
  bit               line_on;
  bit               line_steep;
  bit               min_down;
  int               maj_pos;
  int               maj_stop;
  int               min_pos;
  int               seg_from;
  int               err_acc;
  int               d_maj;
  int               d_min;
  logic [COLOR_W-1:0] ink;

  out_item_t runs_due[$];
  int        n_fail;
  int        n_runs;
  int        n_last;

  task automatic report_mismatch(input string what);
    if (n_fail < 40) $display("[%0t] run mismatch: %s", $realtime, what);
    n_fail++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  function automatic int span(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Clips one run to the screen; returns 0 when nothing of it is visible.
  function automatic bit clip_run(input int mstart, input int minor, input int len,
                                  input bit done, output out_item_t run);
    int x, y, along, lim;
    run   = '0;
    x     = line_steep ? minor : mstart;
    y     = line_steep ? mstart : minor;
    along = line_steep ? y : x;
    lim   = line_steep ? scr_h : scr_w;
    if (x >= scr_w || y >= scr_h || len < 1) return 1'b0;
    if (along + len - 1 >= lim) len = lim - along;
    run.run_x      = x[DIM_W-1:0];
    run.run_y      = y[DIM_W-1:0];
    run.run_length = len[DIM_W-1:0];
    run.vertical   = line_steep;
    run.run_color  = ink;
    run.last       = done;
    return 1'b1;
  endfunction

  function automatic bit rasterize_item(input in_item_t it, output out_item_t run);
    int xa, ya, xb, yb, t, rfrom, rlen, rminor;
    bit have, done;
    run = '0;
    if (it.mode == MODE_START) begin
      xa = $signed(it.x_start);
      ya = $signed(it.y_start);
      xb = $signed(it.x_end);
      yb = $signed(it.y_end);
      ink = it.pen_color;
      line_on = 1'b0;
      if ((ya < 0 && yb < 0) || (ya > scr_h && yb > scr_h)) return 1'b0;
      if ((xa < 0 && xb < 0) || (xa > scr_w && xb > scr_w)) return 1'b0;
      if (xa < 0) xa = 0;
      if (xb < 0) xb = 0;
      if (ya < 0) ya = 0;
      if (yb < 0) yb = 0;
      line_steep = span(ya, yb) > span(xa, xb);
      if (line_steep) begin
        t = xa; xa = ya; ya = t;
        t = xb; xb = yb; yb = t;
      end
      if (xa > xb) begin
        t = xa; xa = xb; xb = t;
        t = ya; ya = yb; yb = t;
      end
      d_maj    = xb - xa;
      d_min    = span(ya, yb);
      err_acc  = d_maj / 2;
      min_down = !(ya < yb);
      maj_pos  = xa;
      maj_stop = xb;
      min_pos  = ya;
      seg_from = xa;
      line_on  = 1'b1;
      return 1'b0;
    end
    if (!line_on) return 1'b0;
    have   = 1'b0;
    rfrom  = 0;
    rlen   = 0;
    rminor = 0;
    err_acc -= d_min;
    // The minor coordinate moves: the run gathered so far is complete.
    if (err_acc < 0) begin
      rfrom    = seg_from;
      rlen     = maj_pos - seg_from + 1;
      rminor   = min_pos;
      have     = 1'b1;
      seg_from = maj_pos + 1;
      min_pos += min_down ? -1 : 1;
      err_acc += d_maj;
    end
    maj_pos++;
    done = maj_pos > maj_stop;
    if (done) begin
      line_on = 1'b0;
      if (!have && maj_pos > seg_from) begin
        rfrom  = seg_from;
        rlen   = maj_pos - seg_from;
        rminor = min_pos;
        have   = 1'b1;
      end
    end
    if (!have) return 1'b0;
    return clip_run(rfrom, rminor, rlen, done, run);
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t run;
    logic [CFG_DATA_W-1:0] reg_val;
    if (!rst_n) begin
      scr_w      = int'(WIDTH_RESET);
      scr_h      = int'(HEIGHT_RESET);
      line_on    = 1'b0;
      line_steep = 1'b0;
      min_down   = 1'b0;
      maj_pos    = 0;
      maj_stop   = 0;
      min_pos    = 0;
      seg_from   = 0;
      err_acc    = 0;
      d_maj      = 0;
      d_min      = 0;
      ink        = '0;
      runs_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        case (cfg_paddr[CFG_ADDR_W-1:2])
          REG_SCREEN_WIDTH:  reg_val = CFG_DATA_W'(scr_w[DIM_W-1:0]);
          REG_SCREEN_HEIGHT: reg_val = CFG_DATA_W'(scr_h[DIM_W-1:0]);
          default:           reg_val = '0;
        endcase
        if (cfg_pwrite) begin
          case (cfg_paddr[CFG_ADDR_W-1:2])
            REG_SCREEN_WIDTH:  scr_w = int'(cfg_pwdata[DIM_W-1:0]);
            REG_SCREEN_HEIGHT: scr_h = int'(cfg_pwdata[DIM_W-1:0]);
            default: ;
          endcase
        end else if (cfg_prdata !== reg_val) begin
          report_mismatch($sformatf("register read at %0d gave %0h, expected %0h",
                                    cfg_paddr, cfg_prdata, reg_val));
        end
      end
      if (in_valid && in_ready) begin
        if (rasterize_item(in_item, run)) runs_due.push_back(run);
      end
      if (out_valid && out_ready) begin
        n_runs++;
        if (out_item.last === 1'b1) n_last++;
        if (runs_due.size() == 0) begin
          report_mismatch("result item arrived with no run expected");
        end else begin
          want = runs_due.pop_front();
          check_field("run_x", int'(out_item.run_x), int'(want.run_x));
          check_field("run_y", int'(out_item.run_y), int'(want.run_y));
          check_field("run_length", int'(out_item.run_length), int'(want.run_length));
          check_field("vertical", int'(out_item.vertical), int'(want.vertical));
          check_field("run_color", int'(out_item.run_color), int'(want.run_color));
          check_field("last", int'(out_item.last), int'(want.last));
        end
      end
    end
    fail_count   <= n_fail;
    runs_pending <= runs_due.size();
    runs_seen    <= n_runs;
    last_seen    <= n_last;
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top of the clipped line run rasterizer: clock, reset, stimulus and verdict.
module tb_top;
  import clr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES     = 6;
  localparam int PHASE_ITEMS = 85;
  localparam int PHASE_W[PHASES] = '{2047, 1, 0, 37, 2047, 240};
  localparam int PHASE_H[PHASES] = '{2047, 2047, 0, 53, 1, 320};

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  in_item_t              in_item     = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b1;
  out_item_t             out_item;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int fail_count;
  int runs_pending;
  int runs_seen;
  int last_seen;
  int item_total = 0;
  int idle_cycles = 0;
  int ready_hold = 0;
  bit calm = 1'b0;

  clipped_line_run_rasterizer u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  clr_run_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_item     (out_item),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .fail_count   (fail_count),
    .runs_pending (runs_pending),
    .runs_seen    (runs_seen),
    .last_seen    (last_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int draw_wait();
    return calm ? 0 : int'($urandom_range(0, 6));
  endfunction

  // After each accepted result the receiver draws a wait from draw_wait and holds ready low until it runs out.
  always @(posedge clk) begin : ready_ctrl
    int hold;
    if (out_valid && out_ready) begin
      hold = draw_wait();
      out_ready  <= (hold == 0);
      ready_hold <= hold;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready  <= (ready_hold == 1);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no handshake for %0d cycles", IDLE_LIMIT);
      $display("clipped_line_run_rasterizer regression: fail");
      $finish;
    end
  end

  task automatic send_item(input in_item_t it);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    item_total++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_start(input int xa, input int ya, input int xb, input int yb,
                            input logic [COLOR_W-1:0] color);
    in_item_t it;
    it.mode      = MODE_START;
    it.x_start   = xa[FIELD_W-1:0];
    it.y_start   = ya[FIELD_W-1:0];
    it.x_end     = xb[FIELD_W-1:0];
    it.y_end     = yb[FIELD_W-1:0];
    it.pen_color = color;
    send_item(it);
  endtask

  // Step items carry random content in the fields the block ignores.
  task automatic send_steps(input int n);
    in_item_t it;
    repeat (n) begin
      it      = in_item_t'({$urandom, $urandom, $urandom});
      it.mode = MODE_STEP;
      send_item(it);
    end
  endtask

  // Starts a line and sends one step per major position, adjusted by cut.
  task automatic draw_line(input int xa, input int ya, input int xb, input int yb,
                           input logic [COLOR_W-1:0] color, input int cut);
    int cxa, cya, cxb, cyb, dx, dy, n;
    cxa = (xa < 0) ? 0 : xa;
    cya = (ya < 0) ? 0 : ya;
    cxb = (xb < 0) ? 0 : xb;
    cyb = (yb < 0) ? 0 : yb;
    dx  = (cxa > cxb) ? cxa - cxb : cxb - cxa;
    dy  = (cya > cyb) ? cya - cyb : cyb - cya;
    n   = ((dx > dy) ? dx : dy) + 1 + cut;
    send_start(xa, ya, xb, yb, color);
    send_steps((n < 0) ? 0 : n);
  endtask

  // Drops valid and waits until every expected run has come out.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (runs_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic idx, input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(input int quota, input int w, input int h);
    int first, pick, reach, cut, xa, ya, xb, yb;
    first = item_total;
    while (item_total - first < quota) begin
      pick  = $urandom_range(0, 15);
      calm  = ($urandom_range(0, 3) == 0);
      reach = (pick == 0) ? 120 : 24;
      if (pick == 1) begin
        // Noise: endpoints anywhere in the coordinate range, then a few steps.
        send_start($urandom, $urandom, $urandom, $urandom, COLOR_W'($urandom));
        send_steps($urandom_range(0, 3));
      end else begin
        xa = int'($urandom_range(0, w + 32)) - 16;
        ya = int'($urandom_range(0, h + 32)) - 16;
        xb = xa + int'($urandom_range(0, 2 * reach)) - reach;
        yb = ya + int'($urandom_range(0, 2 * reach)) - reach;
        if (pick == 2) yb = ya;
        if (pick == 3) xb = xa;
        cut = (pick == 4) ? -int'($urandom_range(1, 6)) :
              (pick == 5) ? int'($urandom_range(1, 2)) : 0;
        draw_line(xa, ya, xb, yb, COLOR_W'($urandom), cut);
      end
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] data;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    apb_access(1'b0, REG_SCREEN_WIDTH, '0);
    apb_access(1'b0, REG_SCREEN_HEIGHT, '0);

    // Directed lines on the reset screen size.
    send_steps(1);
    draw_line(5, 7, 9, 7, 16'hFFFF, 0);
    draw_line(3, 12, 3, 10, 16'h0000, 0);
    draw_line(0, 0, 0, 0, 16'h5A5A, 0);
    send_start(300, 5, 32767, 6, 16'h00FF);
    send_start(5, -32768, 6, -1, 16'hFF00);
    draw_line(237, 100, 241, 101, 16'h1234, 0);
    draw_line(-5, -5, 1, 2, 16'hABCD, 0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      // A line wholly left of the screen leaves the block with no line in progress.
      send_start(-1, 0, -1, 0, '0);
      settle();
      data = $urandom;
      data[DIM_W-1:0] = PHASE_W[p][DIM_W-1:0];
      apb_access(1'b1, REG_SCREEN_WIDTH, data);
      data = $urandom;
      data[DIM_W-1:0] = PHASE_H[p][DIM_W-1:0];
      apb_access(1'b1, REG_SCREEN_HEIGHT, data);
      apb_access(1'b0, REG_SCREEN_WIDTH, '0);
      apb_access(1'b0, REG_SCREEN_HEIGHT, '0);
      random_phase(PHASE_ITEMS, PHASE_W[p], PHASE_H[p]);
    end
    calm = 1'b0;
    settle();

    $display("Drove %0d input items across %0d screen sizes, zero and full size included.",
             item_total, PHASES + 1);
    $display("Checked %0d runs, %0d of them closing a line.", runs_seen, last_seen);
    if (fail_count == 0) begin
      $display("clipped_line_run_rasterizer regression: pass");
    end else begin
      $display("clipped_line_run_rasterizer regression: fail");
    end
    $finish;
  end

endmodule
